FILE: rtl/core/bounded_stack_with_search_assert.svh
// Assertion macros for the bounded stack with search.
// Included by the checker module; depends on signals clk and rst_n in scope.
`ifndef BOUNDED_STACK_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_STACK_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BSWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication, checked in reset as well.
`define BSWS_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/bsws_pkg.sv
// Shared types and constants for the bounded stack with search.
// No dependencies; imported by bsws_ram, bsws_ctrl and the top level.
package bsws_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 3;
  localparam int CAP_W     = 5;
  localparam int IDX_W     = 4;
  localparam int COUNT_W   = 5;
  localparam int OUT_W     = 48;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_SCAN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic               status;
    logic [DATA_W-1:0]  data;
    logic               found;
    logic [IDX_W-1:0]   index;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;
  } res_t;

endpackage

FILE: rtl/core/bsws_ram.sv
// Storage array of the stack: one write port and one registered read port.
// Depends on bsws_pkg for the word width.
module bsws_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [bsws_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [bsws_pkg::DATA_W-1:0] rdata
);
  import bsws_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/bsws_ctrl.sv
// Command sequencer: stack pointer, storage addressing and the key comparator for search.
// Depends on bsws_pkg; drives bsws_ram and hands finished results to the top level.
module bsws_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [bsws_pkg::FUNC_W-1:0] in_func,
  input  logic [bsws_pkg::DATA_W-1:0] in_value,
  input  logic [bsws_pkg::CAP_W-1:0]  capacity,
  input  logic                        out_free,
  output logic                        fin_valid,
  output bsws_pkg::res_t              fin,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [bsws_pkg::DATA_W-1:0] ram_wdata,
  output logic [AW-1:0]               ram_raddr,
  input  logic [bsws_pkg::DATA_W-1:0] ram_rdata
);
  import bsws_pkg::*;

  localparam int TPW  = $clog2(DEPTH + 1);
  localparam int CMPW = (TPW > CAP_W) ? TPW : CAP_W;
  localparam int IXW  = (AW > IDX_W) ? AW : IDX_W;

  state_t             state_r, state_nxt;
  logic [FUNC_W-1:0]  func_r;
  logic [DATA_W-1:0]  key_r;
  logic [TPW-1:0]     tp_r, tp_nxt;
  logic [AW-1:0]      scan_r, scan_nxt;
  res_t               hold_r, hold_nxt;
  res_t               res;
  logic               done;
  logic [CMPW-1:0]    cap_eff;
  logic [CMPW-1:0]    tp_cmp;
  logic [CMPW-1:0]    tp_new_cmp;
  logic [IXW-1:0]     idx_ext;

  assign cap_eff = (CMPW'(capacity) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(capacity);
  assign tp_cmp  = CMPW'(tp_r);
  assign in_tready = (state_r == ST_IDLE);
  assign ram_wdata = key_r;
  assign ram_waddr = AW'(tp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      tp_r    <= tp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= in_func;
      key_r  <= in_value;
    end
    scan_r <= scan_nxt;
    hold_r <= hold_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    tp_nxt     = tp_r;
    scan_nxt   = scan_r;
    ram_we     = 1'b0;
    ram_raddr  = AW'(tp_r - TPW'(1));
    done       = 1'b0;
    res        = '0;
    fin_valid  = 1'b0;
    fin        = hold_r;
    hold_nxt   = hold_r;
    idx_ext    = IXW'(scan_r);
    tp_new_cmp = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (func_r)
          OP_PUSH: begin
            if (tp_cmp >= cap_eff) begin
              res.status = 1'b1;
            end else begin
              ram_we = 1'b1;
              tp_nxt = tp_r + TPW'(1);
            end
            done = 1'b1;
          end
          OP_POP: begin
            if (tp_r == '0) begin
              res.status = 1'b1;
              done       = 1'b1;
            end else begin
              tp_nxt    = tp_r - TPW'(1);
              state_nxt = ST_LOAD;
            end
          end
          OP_PEEK: begin
            if (tp_r == '0) begin
              res.status = 1'b1;
              done       = 1'b1;
            end else begin
              state_nxt = ST_LOAD;
            end
          end
          OP_CLEAR: begin
            tp_nxt = '0;
            done   = 1'b1;
          end
          OP_SEARCH: begin
            if (tp_r == '0) begin
              done = 1'b1;
            end else begin
              scan_nxt  = AW'(tp_r - TPW'(1));
              state_nxt = ST_SCAN;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      ST_LOAD: begin
        res.data = ram_rdata;
        done     = 1'b1;
      end
      ST_SCAN: begin
        ram_raddr = scan_r - AW'(1);
        if (ram_rdata == key_r) begin
          res.found = 1'b1;
          res.index = idx_ext[IDX_W-1:0];
          done      = 1'b1;
        end else if (scan_r == '0) begin
          done = 1'b1;
        end else begin
          scan_nxt = scan_r - AW'(1);
        end
      end
      ST_HOLD: begin
        fin_valid = 1'b1;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (done) begin
      tp_new_cmp   = CMPW'(tp_nxt);
      res.count    = tp_new_cmp[COUNT_W-1:0];
      res.is_empty = (tp_nxt == '0);
      res.is_full  = (tp_new_cmp >= cap_eff);
      fin_valid    = 1'b1;
      fin          = res;
      hold_nxt     = res;
      state_nxt    = out_free ? ST_IDLE : ST_HOLD;
    end
  end

endmodule

FILE: rtl/core/bounded_stack_with_search.sv
// Bounded LIFO stack of signed words with a top-down search: top level.
// Depends on bsws_pkg, bsws_ctrl and bsws_ram; holds the capacity register and output stage.
//
// Usage. Each input beat is one command: in_tuser carries the operation (push, pop,
// peek, clear or search) and in_tdata the word to push or the key to search for.
// Every command returns exactly one output beat carrying status, data, search hit,
// index, count and the empty and full flags. The capacity register is written through
// cfg_we and cfg_wdata; the user must write it only while no command is outstanding,
// as the block does not enforce this. Values above the built depth act as the depth.
// Push, clear, failed commands and searches of an empty stack finish in the execute
// state; pop and peek pass through a load state as well, as the storage read is
// registered. A search scans one entry per cycle from the top.
// in_tready is high only while the sequencer is idle, so one command is in work at a
// time.
// A finished result sits in the output register; the next command is taken while it
// waits. If the receiver stalls and a further result is finished, the sequencer holds
// it and drops in_tready until the output register frees.
// Synchronous reset empties the stack, sets capacity to sixteen and drops out_tvalid;
// the storage contents are not cleared and need no clearing pass.
module bounded_stack_with_search #(
  parameter int DEPTH = bsws_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // value[31:0]
  input  logic [2:0]                  in_tuser,   // func[2:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // status[0], data[32:1], found[33], index[37:34], count[42:38],
  // is_empty[43], is_full[44], zero[47:45]
  output logic [bsws_pkg::OUT_W-1:0]  out_tdata,
  input  logic                        cfg_we,
  input  logic [bsws_pkg::CAP_W-1:0]  cfg_wdata
);
  import bsws_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CAP_W-1:0]  capacity_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;
  logic              out_free;
  logic              fin_valid;
  res_t              fin;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      if (out_free) begin
        out_valid_r <= fin_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fin_valid) begin
      out_data_r <= {3'b000, fin.is_full, fin.is_empty, fin.count, fin.index,
                     fin.found, fin.data, fin.status};
    end
  end

  bsws_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_tuser),
    .in_value  (in_tdata),
    .capacity  (capacity_r),
    .out_free  (out_free),
    .fin_valid (fin_valid),
    .fin       (fin),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bsws_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: rtl/core/bsws_checker.sv
// Port-level checks on the result channel of the bounded stack with search.
// Depends on bounded_stack_with_search_assert.svh; bound to the top level below.
`include "bounded_stack_with_search_assert.svh"

module bsws_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  `BSWS_ASSERT_ALWAYS(a_reset_idle, !rst_n, !out_tvalid, "result beat valid after reset")
  `BSWS_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result beat changed")
  `BSWS_ASSERT_NOW(a_empty_flag, out_tvalid, out_tdata[43] == (out_tdata[42:38] == 5'd0), "empty flag disagrees with count")
  `BSWS_ASSERT_NOW(a_error_clean, out_tvalid && out_tdata[0], out_tdata[33:1] == 33'd0, "error beat carries data or hit")
  `BSWS_ASSERT_NOW(a_miss_index, out_tvalid && !out_tdata[33], out_tdata[37:34] == 4'd0, "index set without a search hit")

endmodule

bind bounded_stack_with_search bsws_checker u_bsws_checker (.*);
